>>> sv/sha256_message_digest_macros.svh
// Assertion helpers for the SHA-256 hasher.
// Each macro expands to one labelled concurrent assertion on aclk,
// switched off while aresetn is low.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sha256md_pkg.sv
package sha256md_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } sha_state_t;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] BLK_LAST  = 6'd63;
    localparam logic [5:0] RND_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;
    localparam logic [5:0] BYTE_BITS = 6'd8;

    localparam word_t INIT_VEC [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    function automatic word_t round_const(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> sv/sha256_message_digest.sv
// SHA-256 hasher, one message byte per input transaction.
// Input channel (s_): tdata = message byte, tuser = byte present flag,
// tlast = end of message. A transaction with tuser low and tlast high
// closes the message without adding a byte; tuser and tlast both low is
// a no-op. Output channel (m_): eight transactions per message, tdata =
// digest word, tuser = word index (0 most significant), tlast on word 7.
// A byte is accepted while the hasher is idle. Each completed 64-byte block
// holds s_tready low for 64 rounds of the single round unit, then a fold
// into the chaining value, so no new byte is taken until both are done.
// On the end of message the padding is shifted in one byte per cycle
// (64 minus the fill level) and the block is compressed; with a fill level
// of 56 or more a second block follows, another 64 padding bytes and a
// second compression. The digest words are then offered; s_tready stays
// low until word 7 is taken. A stall on m_tready simply holds the current
// word. After the last word the chaining value returns to the initial
// vector. Reset (aresetn low at a clock edge) drops any partial message.
`include "sha256_message_digest_macros.svh"

module sha256_message_digest
    import sha256md_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    sha_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        first_reg, first_next;
    logic        lenok_reg, lenok_next;
    logic        done_reg, done_next;
    word_t       chain_reg [8];
    word_t       chain_next [8];
    word_t       win_reg [16];
    word_t       win_next [16];
    word_t       wv_reg [8];
    word_t       wv_next [8];

    logic        s_acc;
    logic        m_acc;
    logic        shift_en;
    logic [7:0]  pad_byte;
    logic [7:0]  byte_in;
    logic [5:0]  len_sh;
    word_t       w_new;
    word_t       t1;
    word_t       t2;
    word_t       ch;
    word_t       maj;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] && cnt_reg == BLK_LAST) begin
                        state_next = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (cnt_reg == BLK_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (done_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_tready && idx_reg == WORD_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Port outputs
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign m_tdata = chain_reg[idx_reg];
    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == WORD_LAST);

    // Padding byte: marker, zeros, then the bit length big-endian
    assign len_sh = {3'd7 - cnt_reg[2:0], 3'b000};
    always_comb begin
        if (first_reg) begin
            pad_byte = PAD_MARK;
        end else if (lenok_reg && cnt_reg >= LEN_POS) begin
            pad_byte = 8'(len_reg >> len_sh);
        end else begin
            pad_byte = '0;
        end
    end

    assign byte_in  = (state_reg == ST_IDLE) ? s_tdata : pad_byte;
    assign shift_en = (s_acc && s_tuser[0]) || (state_reg == ST_PAD);

    // Shared round unit: message schedule and one compression round
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];
    assign ch    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                 ^ (wv_reg[1] & wv_reg[2]);
    assign t1    = wv_reg[7] + big_sigma1(wv_reg[4]) + ch
                 + round_const(rnd_reg) + win_reg[0];
    assign t2    = big_sigma0(wv_reg[0]) + maj;

    // Datapath next values
    always_comb begin
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        lenok_next = lenok_reg;
        done_next  = done_reg;
        chain_next = chain_reg;
        win_next   = win_reg;
        wv_next    = wv_reg;

        // Take a new transaction
        if (s_acc) begin
            fin_next   = s_tlast;
            first_next = 1'b1;
            done_next  = 1'b0;
            if (s_tuser[0]) begin
                len_next = len_reg + 64'(BYTE_BITS);
            end
        end

        // Shift one byte into the block buffer
        if (shift_en) begin
            cnt_next = cnt_reg + 6'd1;
            for (int i = 0; i < 15; i++) begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], byte_in};
        end

        // Track padding progress
        if (state_reg == ST_PAD) begin
            first_next = 1'b0;
            if (first_reg) begin
                lenok_next = (cnt_reg < LEN_POS);
            end else if (lenok_reg && cnt_reg >= LEN_POS) begin
                done_next = 1'b1;
            end
        end

        // Run one round and advance the schedule window
        if (state_reg == ST_ROUND) begin
            rnd_next = rnd_reg + 6'd1;
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_new;
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end

        // Load working variables at the start of a compression
        if (state_next == ST_ROUND && state_reg != ST_ROUND) begin
            wv_next = chain_reg;
        end

        // Fold the compressed block into the chaining value
        if (state_reg == ST_FINAL) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + wv_reg[i];
            end
            if (fin_reg && !done_reg) begin
                lenok_next = 1'b1;
            end
        end

        // Step through the digest words; restart after the last
        if (m_acc) begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg == WORD_LAST) begin
                chain_next = INIT_VEC;
                len_next   = '0;
                fin_next   = 1'b0;
            end
        end
    end

    // Control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            lenok_reg <= 1'b0;
            done_reg  <= 1'b0;
            chain_reg <= INIT_VEC;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            lenok_reg <= lenok_next;
            done_reg  <= done_next;
            chain_reg <= chain_next;
        end
    end

    // Block buffer and working variables
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        wv_reg  <= wv_next;
    end

    `SHA_ASSERT_NOW(a_one_side, s_tready, !m_tvalid, "input and output open together")
    `SHA_ASSERT_NOW(a_rnd_idle, state_reg != ST_ROUND, rnd_reg == '0, "round count left over")
    `SHA_ASSERT_NOW(a_out_empty, m_tvalid, cnt_reg == '0, "digest offered with bytes pending")
    `SHA_ASSERT_NEXT(a_restart, m_acc && m_tlast, s_tready && idx_reg == '0, "no restart")

endmodule
